// ===== sv/multilevel_feedback_scheduler_assert.svh =====
// Assertion macros used by the scheduler controller.
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define MFS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define MFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/mfs_pkg.sv =====
package mfs_pkg;

  localparam int unsigned NumLevels = 40;
  localparam int unsigned LvlW      = 6;
  localparam int unsigned SliceW    = 5;
  localparam logic [LvlW-1:0] TopLevel = 6'd39;

  typedef enum logic [2:0] {
    CMD_ENQ    = 3'd0,
    CMD_WAKE   = 3'd1,
    CMD_DEQ    = 3'd2,
    CMD_YIELD  = 3'd3,
    CMD_TICK   = 3'd4,
    CMD_PICK   = 3'd5,
    CMD_SETLVL = 3'd6,
    CMD_NOP    = 3'd7
  } cmd_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;      // capture input item
    logic prep;      // compute new level, choose target task
    logic unlink;    // remove target from its queue
    logic relevel;   // write level and slice
    logic append;    // add target to tail of its level
    logic pick;      // make highest head current
    logic finish;    // build result
  } mfs_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic valid_op;  // command acts at all
    logic do_unlink;
    logic do_append;
  } mfs_stat_t;

  // Slice reload by level.
  function automatic logic [SliceW-1:0] slice_for(input logic [LvlW-1:0] lv);
    logic [SliceW-1:0] s;
    begin
      if (lv < 6'd10)      s = 5'd16;
      else if (lv < 6'd20) s = 5'd12;
      else if (lv < 6'd30) s = 5'd8;
      else                 s = 5'd4;
      return s;
    end
  endfunction

  // Demote by ten, saturating.
  function automatic logic [LvlW-1:0] expire_level(input logic [LvlW-1:0] lv);
    logic [LvlW-1:0] r;
    begin
      r = (lv < 6'd10) ? '0 : lv - 6'd10;
      return r;
    end
  endfunction

  // Promotion after sleep.
  function automatic logic [LvlW-1:0] sleep_level(input logic [LvlW-1:0] lv);
    logic [LvlW-1:0] r;
    begin
      if (lv < 6'd10)       r = 6'd30;
      else if (lv < 6'd20)  r = 6'd31;
      else if (lv < 6'd25)  r = lv + 6'd12;
      else if (lv < 6'd27)  r = lv + 6'd11;
      else if (lv == 6'd27) r = 6'd37;
      else if (lv < 6'd30)  r = 6'd38;
      else                  r = 6'd39;
      return r;
    end
  endfunction

endpackage

// ===== sv/multilevel_feedback_scheduler.sv =====
// Multilevel feedback queue scheduler, 40 levels, one command per item.
// Input channel: in_valid/in_stall with in_cmd, in_task_id, in_new_level.
// Result channel: out_valid/out_stall with out_found, out_chosen_task,
// out_resched, out_task_level, out_slice_left; one result per command.
// From acceptance to out_valid an item walks through prepare,
// optional unlink, level write, optional append and result build. The
// controller walks these steps one at a time, so a new item is taken
// only after the previous result has been delivered.
// Reset (rst_n low, synchronous) empties every queue, clears levels and
// slices to 0 and drops the current task.
// While out_stall is high the result holds and in_stall stays high.
// Command 7 is a no-operation and returns an all-zero result.
module multilevel_feedback_scheduler #(
  parameter int unsigned MAX_TASKS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_cmd,
  input  logic [3:0] in_task_id,
  input  logic [5:0] in_new_level,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_found,
  output logic [3:0] out_chosen_task,
  output logic       out_resched,
  output logic [5:0] out_task_level,
  output logic [4:0] out_slice_left
);

  mfs_pkg::mfs_cmd_t  cmd;
  mfs_pkg::mfs_stat_t stat;

  mfs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
  );

  mfs_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_cmd(in_cmd), .in_task_id(in_task_id), .in_new_level(in_new_level),
    .out_found(out_found), .out_chosen_task(out_chosen_task),
    .out_resched(out_resched), .out_task_level(out_task_level),
    .out_slice_left(out_slice_left)
  );

endmodule

// ===== sv/mfs_ctrl.sv =====
`include "multilevel_feedback_scheduler_assert.svh"

module mfs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  mfs_pkg::mfs_stat_t stat,
  output mfs_pkg::mfs_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PREP, ST_UNLINK, ST_RELEVEL, ST_APPEND, ST_FINISH, ST_OUT
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Decode commands from the current state.
  always_comb begin
    cmd         = '0;
    cmd.load    = (state_r == ST_IDLE) && in_valid;
    cmd.prep    = (state_r == ST_PREP);
    cmd.unlink  = (state_r == ST_UNLINK);
    cmd.relevel = (state_r == ST_RELEVEL);
    cmd.append  = (state_r == ST_APPEND);
    cmd.pick    = (state_r == ST_PREP);
    cmd.finish  = (state_r == ST_FINISH);
  end

  // Sequence one item at a time.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE:    if (in_valid) state_r <= ST_PREP;
        ST_PREP:    state_r <= stat.do_unlink ? ST_UNLINK : ST_RELEVEL;
        ST_UNLINK:  state_r <= ST_RELEVEL;
        ST_RELEVEL: state_r <= (stat.valid_op && stat.do_append) ? ST_APPEND : ST_FINISH;
        ST_APPEND:  state_r <= ST_FINISH;
        ST_FINISH: begin
          state_r     <= ST_OUT;
          out_valid_r <= 1'b1;
        end
        ST_OUT: if (!out_stall) begin
          state_r     <= ST_IDLE;
          out_valid_r <= 1'b0;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `MFS_ASSERT_IMP(a_out_only_in_out, clk, rst_n, out_valid_r, state_r == ST_OUT)
  `MFS_ASSERT_NEXT(a_load_to_prep, clk, rst_n, cmd.load, state_r == ST_PREP)
  `MFS_ASSERT_NEXT(a_finish_out, clk, rst_n, cmd.finish, out_valid_r)

endmodule

// ===== sv/mfs_dp.sv =====
module mfs_dp #(
  parameter int unsigned MAX_TASKS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mfs_pkg::mfs_cmd_t  cmd,
  output mfs_pkg::mfs_stat_t stat,
  input  logic [2:0]        in_cmd,
  input  logic [3:0]        in_task_id,
  input  logic [5:0]        in_new_level,
  output logic              out_found,
  output logic [3:0]        out_chosen_task,
  output logic              out_resched,
  output logic [5:0]        out_task_level,
  output logic [4:0]        out_slice_left
);

  localparam int unsigned TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned NL = mfs_pkg::NumLevels;

  // Per-task and per-level state.
  logic [5:0]    lvl_r   [MAX_TASKS];
  logic [4:0]    slc_r   [MAX_TASKS];
  logic [TW-1:0] nxt_r   [MAX_TASKS];
  logic [TW-1:0] prv_r   [MAX_TASKS];
  logic [MAX_TASKS-1:0] queued_r;
  logic [TW-1:0] head_r  [NL];
  logic [TW-1:0] tail_r  [NL];
  logic [NL-1:0] nonempty_r;
  logic [TW-1:0] cur_r;
  logic          cur_valid_r;

  // Registered reads of level head and tail.
  logic [TW-1:0] hd_rd_r;
  logic [TW-1:0] tl_rd_r;

  // Item registers.
  mfs_pkg::cmd_t op_r;
  logic [3:0]    tid_in_r;
  logic [5:0]    nl_r;
  logic [TW-1:0] who_r;
  logic          act_r, app_r, resched_r;
  logic [5:0]    newlvl_r;
  logic [4:0]    newslc_r;
  logic          found_r;
  logic [3:0]    res_task_r;
  logic          res_resched_r;
  logic [5:0]    res_lvl_r;
  logic [4:0]    res_slc_r;

  logic          tid_ok;
  logic [TW-1:0] tid;
  assign tid_ok = ({28'd0, tid_in_r} < 32'(MAX_TASKS));
  assign tid    = tid_ok ? TW'(tid_in_r) : '0;

  // Highest non-empty level.
  logic          any_ne;
  logic [5:0]    top_lv;
  always_comb begin
    any_ne = 1'b0;
    top_lv = '0;
    for (int i = 0; i < NL; i++) begin
      if (nonempty_r[i]) begin
        any_ne = 1'b1;
        top_lv = 6'(i);
      end
    end
  end

  // Decide what the item does.
  logic          p_act, p_unl, p_app, p_res, p_pick;
  logic [TW-1:0] p_who;
  logic [5:0]    p_lvl;
  logic [4:0]    p_slc;
  logic [5:0]    sl;
  always_comb begin
    p_act = 1'b0; p_unl = 1'b0; p_app = 1'b0; p_res = 1'b0; p_pick = 1'b0;
    p_who = tid;
    p_lvl = lvl_r[tid];
    p_slc = slc_r[tid];
    sl    = mfs_pkg::sleep_level(lvl_r[tid]);
    unique case (op_r)
      mfs_pkg::CMD_ENQ, mfs_pkg::CMD_WAKE: begin
        if (tid_ok && !queued_r[tid]) begin
          p_act = 1'b1; p_app = 1'b1;
          if (op_r == mfs_pkg::CMD_WAKE) begin
            p_lvl = sl;
            // A woken task that is already current never requests a reschedule.
            p_res = !cur_valid_r || ((cur_r != tid) && (lvl_r[cur_r] < sl));
          end
        end
      end
      mfs_pkg::CMD_DEQ: begin
        if (tid_ok && queued_r[tid]) begin
          p_act = 1'b1; p_unl = 1'b1;
        end
      end
      mfs_pkg::CMD_YIELD: begin
        p_who = cur_r;
        p_lvl = lvl_r[cur_r];
        p_slc = slc_r[cur_r];
        if (cur_valid_r && queued_r[cur_r]) begin
          p_act = 1'b1; p_unl = 1'b1; p_app = 1'b1;
        end
      end
      mfs_pkg::CMD_TICK: begin
        p_who = cur_r;
        p_lvl = lvl_r[cur_r];
        p_slc = slc_r[cur_r];
        if (cur_valid_r) begin
          p_act = 1'b1;
          if (slc_r[cur_r] > 5'd1) begin
            p_slc = slc_r[cur_r] - 5'd1;
          end else begin
            p_lvl = mfs_pkg::expire_level(lvl_r[cur_r]);
            p_slc = mfs_pkg::slice_for(p_lvl);
            p_res = 1'b1;
            p_unl = queued_r[cur_r];
            p_app = queued_r[cur_r];
          end
        end
      end
      mfs_pkg::CMD_PICK: begin
        p_who = hd_rd_r;
        p_lvl = lvl_r[hd_rd_r];
        p_slc = slc_r[hd_rd_r];
        p_act = any_ne;
        p_pick = any_ne;
      end
      mfs_pkg::CMD_SETLVL: begin
        if (tid_ok) begin
          p_act = 1'b1;
          p_lvl = (nl_r > mfs_pkg::TopLevel) ? mfs_pkg::TopLevel : nl_r;
          p_slc = mfs_pkg::slice_for(p_lvl);
          p_unl = queued_r[tid];
          p_app = queued_r[tid];
        end
      end
      default: ;
    endcase
  end

  assign stat.valid_op  = act_r;
  assign stat.do_unlink = p_unl;
  assign stat.do_append = app_r;

  // Pick the level to read: old level before unlink, new level before
  // append, top level otherwise so pick finds its head ready.
  logic [5:0] rd_lv;
  always_comb begin
    if (cmd.prep)         rd_lv = lvl_r[p_who];
    else if (cmd.relevel) rd_lv = newlvl_r;
    else                  rd_lv = top_lv;
  end

  // Register the head and tail reads ahead of their use.
  always_ff @(posedge clk) begin
    hd_rd_r <= head_r[rd_lv];
    tl_rd_r <= tail_r[rd_lv];
  end

  // Unlink addressing, old level of target.
  logic [5:0]    u_lv;
  logic [TW-1:0] u_nx, u_pv;
  logic          u_hd, u_tl;
  assign u_lv = lvl_r[who_r];
  assign u_nx = nxt_r[who_r];
  assign u_pv = prv_r[who_r];
  assign u_hd = (hd_rd_r == who_r);
  assign u_tl = (tl_rd_r == who_r);

  // Append addressing, current level of target.
  logic [5:0] a_lv;
  assign a_lv = lvl_r[who_r];

  // Item and scheduler state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queued_r    <= '0;
      nonempty_r  <= '0;
      cur_valid_r <= 1'b0;
      cur_r       <= '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        lvl_r[i] <= '0;
        slc_r[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        op_r     <= mfs_pkg::cmd_t'(in_cmd);
        tid_in_r <= in_task_id;
        nl_r     <= in_new_level;
      end
      if (cmd.prep) begin
        act_r     <= p_act;
        app_r     <= p_app;
        resched_r <= p_res;
        who_r     <= p_who;
        newlvl_r  <= p_lvl;
        newslc_r  <= p_slc;
      end
      // Make the picked head current.
      if (cmd.pick && p_pick) begin
        cur_r       <= p_who;
        cur_valid_r <= 1'b1;
      end
      // Remove target from its queue.
      if (cmd.unlink) begin
        queued_r[who_r] <= 1'b0;
        if (u_hd && u_tl) begin
          nonempty_r[u_lv] <= 1'b0;
        end else if (u_hd) begin
          head_r[u_lv] <= u_nx;
        end else if (u_tl) begin
          tail_r[u_lv] <= u_pv;
          nxt_r[u_pv]  <= u_pv;
        end else begin
          nxt_r[u_pv] <= u_nx;
          prv_r[u_nx] <= u_pv;
        end
      end
      // Write new level and slice.
      if (cmd.relevel && act_r) begin
        lvl_r[who_r] <= newlvl_r;
        slc_r[who_r] <= newslc_r;
      end
      // Add target at tail.
      if (cmd.append) begin
        queued_r[who_r] <= 1'b1;
        nxt_r[who_r]    <= who_r;
        if (nonempty_r[a_lv]) begin
          prv_r[who_r]    <= tl_rd_r;
          nxt_r[tl_rd_r]  <= who_r;
          tail_r[a_lv]    <= who_r;
        end else begin
          head_r[a_lv]     <= who_r;
          tail_r[a_lv]     <= who_r;
          prv_r[who_r]     <= who_r;
          nonempty_r[a_lv] <= 1'b1;
        end
      end
      // Build result.
      if (cmd.finish) begin
        found_r       <= act_r;
        res_task_r    <= act_r ? 4'(who_r) : '0;
        res_resched_r <= act_r & resched_r;
        res_lvl_r     <= act_r ? lvl_r[who_r] : '0;
        res_slc_r     <= act_r ? slc_r[who_r] : '0;
      end
    end
  end

  assign out_found       = found_r;
  assign out_chosen_task = res_task_r;
  assign out_resched     = res_resched_r;
  assign out_task_level  = res_lvl_r;
  assign out_slice_left  = res_slc_r;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned NTASK = 16;
  localparam int unsigned WATCH_LIMIT = 20000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] in_cmd;
  logic [3:0] in_task_id;
  logic [5:0] in_new_level;
  logic       out_valid;
  logic       out_stall;
  logic       out_found;
  logic [3:0] out_chosen_task;
  logic       out_resched;
  logic [5:0] out_task_level;
  logic [4:0] out_slice_left;

  multilevel_feedback_scheduler #(.MAX_TASKS(NTASK)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_task_id(in_task_id), .in_new_level(in_new_level),
    .out_valid(out_valid), .out_stall(out_stall), .out_found(out_found),
    .out_chosen_task(out_chosen_task), .out_resched(out_resched),
    .out_task_level(out_task_level), .out_slice_left(out_slice_left)
  );

  typedef struct packed {
    logic       found;
    logic [3:0] who;
    logic       resched;
    logic [5:0] lvl;
    logic [4:0] slice;
  } sched_result_t;

  // Shadow scheduler state
  logic [5:0]  lvl_of [NTASK];
  logic [4:0]  slice_of [NTASK];
  logic [3:0]  nxt [NTASK];
  logic [3:0]  prv [NTASK];
  logic        queued [NTASK];
  logic [3:0]  head_of [mfs_pkg::NumLevels];
  logic [3:0]  tail_of [mfs_pkg::NumLevels];
  logic [39:0] busy_lvls;
  logic [3:0]  cur;
  logic        cur_ok;

  sched_result_t pending_results[$];
  int errors;
  int idle_cycles;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_start;
  int hold_seen;
  int hold_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [4:0] reload_slice(input logic [5:0] lv);
    if (lv < 10) return 5'd16;
    if (lv < 20) return 5'd12;
    if (lv < 30) return 5'd8;
    return 5'd4;
  endfunction

  function automatic logic [5:0] woken_level(input logic [5:0] lv);
    if (lv < 10) return 6'd30;
    if (lv < 20) return 6'd31;
    if (lv < 25) return lv + 6'd12;
    if (lv < 27) return lv + 6'd11;
    if (lv == 27) return 6'd37;
    if (lv < 30) return 6'd38;
    return 6'd39;
  endfunction

  task automatic queue_tail(input logic [3:0] t);
    logic [5:0] lv;
    lv = lvl_of[t];
    if (busy_lvls[lv]) begin
      prv[t] = tail_of[lv];
      nxt[tail_of[lv]] = t;
      tail_of[lv] = t;
    end else begin
      head_of[lv] = t;
      tail_of[lv] = t;
      prv[t] = t;
      busy_lvls[lv] = 1'b1;
    end
    nxt[t] = t;
    queued[t] = 1'b1;
  endtask

  task automatic queue_remove(input logic [3:0] t);
    logic [5:0] lv;
    logic is_head, is_tail;
    lv = lvl_of[t];
    is_head = head_of[lv] == t;
    is_tail = tail_of[lv] == t;
    if (is_head && is_tail) busy_lvls[lv] = 1'b0;
    else if (is_head) head_of[lv] = nxt[t];
    else if (is_tail) begin
      tail_of[lv] = prv[t];
      nxt[prv[t]] = prv[t];
    end else begin
      nxt[prv[t]] = nxt[t];
      prv[nxt[t]] = prv[t];
    end
    queued[t] = 1'b0;
  endtask

  // Advance the shadow scheduler by one command and queue its result
  task automatic schedule_command(input logic [2:0] c, input logic [3:0] t,
                                  input logic [5:0] nl);
    sched_result_t r;
    logic q;
    r = '0;
    case (mfs_pkg::cmd_t'(c))
      mfs_pkg::CMD_ENQ, mfs_pkg::CMD_WAKE: begin
        if (!queued[t]) begin
          if (mfs_pkg::cmd_t'(c) == mfs_pkg::CMD_WAKE) lvl_of[t] = woken_level(lvl_of[t]);
          queue_tail(t);
          if (mfs_pkg::cmd_t'(c) == mfs_pkg::CMD_WAKE)
            r.resched = !cur_ok || lvl_of[cur] < lvl_of[t];
          r.found = 1'b1;
          r.who = t;
        end
      end
      mfs_pkg::CMD_DEQ: begin
        if (queued[t]) begin
          queue_remove(t);
          r.found = 1'b1;
          r.who = t;
        end
      end
      mfs_pkg::CMD_YIELD: begin
        if (cur_ok && queued[cur]) begin
          r.who = cur;
          queue_remove(cur);
          queue_tail(cur);
          r.found = 1'b1;
        end
      end
      mfs_pkg::CMD_TICK: begin
        if (cur_ok) begin
          r.who = cur;
          r.found = 1'b1;
          if (slice_of[cur] > 1) slice_of[cur] = slice_of[cur] - 5'd1;
          else begin
            q = queued[cur];
            if (q) queue_remove(cur);
            lvl_of[cur] = (lvl_of[cur] < 10) ? 6'd0 : lvl_of[cur] - 6'd10;
            slice_of[cur] = reload_slice(lvl_of[cur]);
            if (q) queue_tail(cur);
            r.resched = 1'b1;
          end
        end
      end
      mfs_pkg::CMD_PICK: begin
        for (int lv = mfs_pkg::NumLevels - 1; lv >= 0; lv--) begin
          if (busy_lvls[lv] && !r.found) begin
            r.who = head_of[lv];
            cur = head_of[lv];
            cur_ok = 1'b1;
            r.found = 1'b1;
          end
        end
      end
      mfs_pkg::CMD_SETLVL: begin
        q = queued[t];
        if (q) queue_remove(t);
        lvl_of[t] = (nl > 39) ? 6'd39 : nl;
        slice_of[t] = reload_slice(lvl_of[t]);
        if (q) queue_tail(t);
        r.found = 1'b1;
        r.who = t;
      end
      default: ;
    endcase
    if (r.found) begin
      r.lvl = lvl_of[r.who];
      r.slice = slice_of[r.who];
    end
    pending_results.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Send one item, wait for acceptance; valid stays up until the next idle
  task automatic send_command(input logic [2:0] c, input logic [3:0] t,
                              input logic [5:0] nl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= c;
    in_task_id <= t;
    in_new_level <= nl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    schedule_command(c, t, nl);
  endtask

  // Drive receiver stall; count out a long hold when one is requested
  always @(posedge clk) begin
    if (hold_start != hold_seen) begin
      hold_seen <= hold_start;
      hold_cnt <= 300;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Check each accepted result
  always @(posedge clk) begin
    sched_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_found !== want.found) report_mismatch("found", out_found, want.found);
        if (out_chosen_task !== want.who)
          report_mismatch("chosen_task", out_chosen_task, want.who);
        if (out_resched !== want.resched)
          report_mismatch("resched", out_resched, want.resched);
        if (out_task_level !== want.lvl)
          report_mismatch("task_level", out_task_level, want.lvl);
        if (out_slice_left !== want.slice)
          report_mismatch("slice_left", out_slice_left, want.slice);
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("multilevel_feedback_scheduler test failed");
      $finish;
    end
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic test_directed();
    send_command(mfs_pkg::CMD_PICK, 0, 0);
    send_command(mfs_pkg::CMD_TICK, 0, 0);
    send_command(mfs_pkg::CMD_YIELD, 0, 0);
    send_command(mfs_pkg::CMD_DEQ, 3, 0);
    send_command(mfs_pkg::CMD_ENQ, 0, 0);
    send_command(mfs_pkg::CMD_ENQ, 0, 0);
    send_command(mfs_pkg::CMD_SETLVL, 15, 63);
    send_command(mfs_pkg::CMD_SETLVL, 1, 39);
    send_command(mfs_pkg::CMD_SETLVL, 2, 20);
    send_command(mfs_pkg::CMD_WAKE, 15, 0);
    send_command(mfs_pkg::CMD_WAKE, 2, 0);
    send_command(mfs_pkg::CMD_ENQ, 1, 0);
    send_command(mfs_pkg::CMD_PICK, 0, 0);
    send_command(mfs_pkg::CMD_YIELD, 0, 0);
    repeat (5) send_command(mfs_pkg::CMD_TICK, 0, 0);
    send_command(mfs_pkg::CMD_WAKE, 5, 0);
    send_command(mfs_pkg::CMD_DEQ, 1, 0);
    send_command(mfs_pkg::CMD_DEQ, 15, 0);
    send_command(mfs_pkg::CMD_SETLVL, 2, 0);
    send_command(mfs_pkg::CMD_NOP, 4'hf, 6'h3f);
    send_command(mfs_pkg::CMD_PICK, 0, 0);
  endtask

  // Mostly valid commands over a small task set
  task automatic test_random(input int count, input int sidle, input int rstall);
    int k;
    logic [2:0] c;
    logic [3:0] t;
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(99);
      if (k < 18) c = mfs_pkg::CMD_ENQ;
      else if (k < 30) c = mfs_pkg::CMD_WAKE;
      else if (k < 42) c = mfs_pkg::CMD_DEQ;
      else if (k < 52) c = mfs_pkg::CMD_YIELD;
      else if (k < 72) c = mfs_pkg::CMD_TICK;
      else if (k < 84) c = mfs_pkg::CMD_PICK;
      else if (k < 97) c = mfs_pkg::CMD_SETLVL;
      else c = mfs_pkg::CMD_NOP;
      t = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(5));
      send_command(c, t, 6'($urandom_range(63)));
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // Hold the receiver off while items keep coming
  task automatic test_backpressure();
    hold_start = hold_start + 1;
    for (int i = 0; i < 20; i++)
      send_command(3'($urandom_range(7)), 4'($urandom_range(15)),
                   6'($urandom_range(63)));
  endtask

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_start = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = '0;
    in_task_id = '0;
    in_new_level = '0;
    for (int i = 0; i < NTASK; i++) begin
      lvl_of[i] = '0;
      slice_of[i] = '0;
      nxt[i] = '0;
      prv[i] = '0;
      queued[i] = 1'b0;
    end
    for (int i = 0; i < mfs_pkg::NumLevels; i++) begin
      head_of[i] = '0;
      tail_of[i] = '0;
    end
    busy_lvls = '0;
    cur = '0;
    cur_ok = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(450, 0, 0);
    test_random(400, 67, 0);
    test_random(400, 0, 67);
    test_random(450, 27, 27);
    test_backpressure();
    wait_drained();
    if (errors == 0) $display("multilevel_feedback_scheduler test passed");
    else $display("multilevel_feedback_scheduler test failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/mfs_pkg.sv
sv/mfs_ctrl.sv
sv/mfs_dp.sv
sv/multilevel_feedback_scheduler.sv
verif/testbench.sv
